// ===== design/scot_pkg.sv =====
`timescale 1ns / 1ps

package scot_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned FIELD_W       = 16;
  localparam int unsigned RAD_W         = 15;
  localparam int unsigned RAD2_W        = 2 * RAD_W;

  // Default coordinate width and the cross-product magnitude limit.
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned CROSS_LIMIT_W  = 32;

  typedef struct packed {
    logic signed [FIELD_W-1:0] seg_start_x;
    logic signed [FIELD_W-1:0] seg_start_y;
    logic signed [FIELD_W-1:0] seg_end_x;
    logic signed [FIELD_W-1:0] seg_end_y;
    logic signed [FIELD_W-1:0] circle_x;
    logic signed [FIELD_W-1:0] circle_y;
    logic        [RAD_W-1:0]   circle_radius;
    logic signed [FIELD_W-1:0] shift_x;
    logic signed [FIELD_W-1:0] shift_y;
  } in_beat_t;

  typedef struct packed {
    logic touches;
  } out_beat_t;

endpackage

// ===== design/scot_stream_if.sv =====
`timescale 1ns / 1ps

interface scot_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== design/segment_circle_overlap_test_top.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Payload              | Handshake
// --------+-----+----------------------+-------------------------------------
// in_i    | in  | scot_pkg::in_beat_t  | beat taken when valid && ready
// out_o   | out | scot_pkg::out_beat_t | beat taken when valid && ready
//
// Throughput: one beat per cycle while out_o does not stall.
// The depth follows the arithmetic chain: differences, first products, sums,
// clamp decisions, the cross-squared and radius-times-length products, the
// final compare. Each multiply has a register behind it.
// Reset clears only the per-stage valid bits; the data registers are not reset.
// On a stall, ready walks back stage by stage: a stage with no beat still loads,
// so bubbles get squeezed out and nothing is dropped or repeated.
module segment_circle_overlap_test_top #(
  parameter int unsigned COORD_BITS = scot_pkg::COORD_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  scot_stream_if.sink    in_i,
  scot_stream_if.source  out_o
);

  import scot_pkg::*;

  // Coordinate width actually used: the field is cut to at most its own width.
  localparam int unsigned CW   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  // Differences: center and edge vector need CW+1, center-to-point needs CW+2.
  localparam int unsigned VW   = CW + 1;
  localparam int unsigned PW   = CW + 2;
  // First products and their sums.
  localparam int unsigned MW   = 2 * CW + 4;
  localparam int unsigned DW   = MW + 1;
  // Squared length is non-negative and below 2^(2*CW+1).
  localparam int unsigned LW   = 2 * CW + 1;
  // Cross magnitude kept for squaring.
  localparam int unsigned AW   = (DW < CROSS_LIMIT_W) ? DW : CROSS_LIMIT_W;
  // Width for the endpoint distance compare against r^2.
  localparam int unsigned EW   = (DW > RAD2_W + 1) ? DW : RAD2_W + 1;
  // Width for the interior compare.
  localparam int unsigned CPW  = (2 * AW > RAD2_W + LW) ? 2 * AW : RAD2_W + LW;
  localparam int unsigned NS   = 6;

  // -------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its beat moves on.
  // -------------------------------------------------------------------------
  logic [NS-1:0] v_q;
  logic [NS:0]   en;
  logic [NS-1:0] vin;

  always_comb begin
    en[NS] = out_o.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign vin = {v_q[NS-2:0], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  assign in_i.ready = en[0];

  // -------------------------------------------------------------------------
  // Stage 0: cut coordinates, shift the center, form difference vectors.
  // -------------------------------------------------------------------------
  logic signed [CW-1:0] sx, sy, ex, ey, ccx, ccy, shx, shy;
  logic signed [VW-1:0] cx, cy;
  logic signed [VW-1:0] vx_d, vy_d, vx_q, vy_q;
  logic signed [PW-1:0] px_d, py_d, qx_d, qy_d, px_q, py_q, qx_q, qy_q;
  logic [RAD_W-1:0]     r_q;

  assign sx  = $signed(in_i.data.seg_start_x[CW-1:0]);
  assign sy  = $signed(in_i.data.seg_start_y[CW-1:0]);
  assign ex  = $signed(in_i.data.seg_end_x[CW-1:0]);
  assign ey  = $signed(in_i.data.seg_end_y[CW-1:0]);
  assign ccx = $signed(in_i.data.circle_x[CW-1:0]);
  assign ccy = $signed(in_i.data.circle_y[CW-1:0]);
  assign shx = $signed(in_i.data.shift_x[CW-1:0]);
  assign shy = $signed(in_i.data.shift_y[CW-1:0]);

  assign cx   = VW'(ccx) - VW'(shx);
  assign cy   = VW'(ccy) - VW'(shy);
  assign vx_d = VW'(ex) - VW'(sx);
  assign vy_d = VW'(ey) - VW'(sy);
  assign px_d = PW'(cx) - PW'(sx);
  assign py_d = PW'(cy) - PW'(sy);
  assign qx_d = PW'(cx) - PW'(ex);
  assign qy_d = PW'(cy) - PW'(ey);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      vx_q <= vx_d;
      vy_q <= vy_d;
      px_q <= px_d;
      py_q <= py_d;
      qx_q <= qx_d;
      qy_q <= qy_d;
      r_q  <= in_i.data.circle_radius;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1: all first-level products.
  // -------------------------------------------------------------------------
  logic signed [MW-1:0] m_dot_a_q, m_dot_b_q, m_len_a_q, m_len_b_q;
  logic signed [MW-1:0] m_cr_a_q, m_cr_b_q, m_ds_a_q, m_ds_b_q, m_de_a_q, m_de_b_q;
  logic [RAD2_W-1:0]    r2_1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      m_dot_a_q <= MW'(px_q) * MW'(vx_q);
      m_dot_b_q <= MW'(py_q) * MW'(vy_q);
      m_len_a_q <= MW'(vx_q) * MW'(vx_q);
      m_len_b_q <= MW'(vy_q) * MW'(vy_q);
      m_cr_a_q  <= MW'(px_q) * MW'(vy_q);
      m_cr_b_q  <= MW'(py_q) * MW'(vx_q);
      m_ds_a_q  <= MW'(px_q) * MW'(px_q);
      m_ds_b_q  <= MW'(py_q) * MW'(py_q);
      m_de_a_q  <= MW'(qx_q) * MW'(qx_q);
      m_de_b_q  <= MW'(qy_q) * MW'(qy_q);
      r2_1_q    <= RAD2_W'(r_q) * RAD2_W'(r_q);
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: dot, squared length, cross, endpoint distances.
  // -------------------------------------------------------------------------
  logic signed [DW-1:0] dot_q, len2_q, cross_q, ds_q, de_q;
  logic [RAD2_W-1:0]    r2_2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      dot_q   <= DW'(m_dot_a_q) + DW'(m_dot_b_q);
      len2_q  <= DW'(m_len_a_q) + DW'(m_len_b_q);
      cross_q <= DW'(m_cr_a_q) - DW'(m_cr_b_q);
      ds_q    <= DW'(m_ds_a_q) + DW'(m_ds_b_q);
      de_q    <= DW'(m_de_a_q) + DW'(m_de_b_q);
      r2_2_q  <= r2_1_q;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 3: clamp decision, endpoint hits, cross magnitude.
  // A zero-length segment has dot zero and so falls to the start point.
  // -------------------------------------------------------------------------
  logic                 le0, ge_len, hit_s, hit_e;
  logic [DW-1:0]        mag;
  logic                 mid_3_q, end_hit_3_q, big_3_q;
  logic [AW-1:0]        acr_q;
  logic [LW-1:0]        len2_3_q;
  logic [RAD2_W-1:0]    r2_3_q;
  logic signed [EW-1:0] r2_ext;

  assign le0    = dot_q[DW-1] || (dot_q == '0);
  assign ge_len = dot_q >= len2_q;
  assign r2_ext = EW'($signed({1'b0, r2_2_q}));
  assign hit_s  = EW'(ds_q) <= r2_ext;
  assign hit_e  = EW'(de_q) <= r2_ext;
  assign mag    = cross_q[DW-1] ? DW'(-cross_q) : DW'(cross_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      mid_3_q     <= !le0 && !ge_len;
      end_hit_3_q <= le0 ? hit_s : hit_e;
      // Past 2^32 the squared cross beats any r^2 * len2.
      big_3_q     <= (mag >> CROSS_LIMIT_W) != '0;
      acr_q       <= mag[AW-1:0];
      len2_3_q    <= len2_q[LW-1:0];
      r2_3_q      <= r2_2_q;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 4: cross squared and r^2 times squared length.
  // -------------------------------------------------------------------------
  logic [2*AW-1:0]        acr2_q;
  logic [RAD2_W+LW-1:0]   rl_q;
  logic                   mid_4_q, end_hit_4_q, big_4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      acr2_q      <= (2 * AW)'(acr_q) * (2 * AW)'(acr_q);
      rl_q        <= (RAD2_W + LW)'(r2_3_q) * (RAD2_W + LW)'(len2_3_q);
      mid_4_q     <= mid_3_q;
      end_hit_4_q <= end_hit_3_q;
      big_4_q     <= big_3_q;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 5: interior compare and final select; this is the output register.
  // -------------------------------------------------------------------------
  logic hit_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      hit_q <= mid_4_q ? (!big_4_q && (CPW'(acr2_q) <= CPW'(rl_q))) : end_hit_4_q;
    end
  end

  assign out_o.valid        = v_q[NS-1];
  assign out_o.data.touches = hit_q;

endmodule
